>>> hw/rtl/cciprw_pkg.sv
// ----------------------------------------------------------------------------
// CAPWAP control address rewriter package
// Shared payload types, widths and protocol constants.
// ----------------------------------------------------------------------------
package cciprw_pkg;

  localparam int MAX_PACKET = 2048;
  localparam int POS_W      = $clog2(MAX_PACKET + 1);

  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam int NUM_REGS = 2;
  localparam int REG_W    = 32;
  localparam int IDX_W    = $clog2(NUM_REGS);

  localparam logic [IDX_W-1:0] REG_LISTEN_IPV4    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_REWRITE_ENABLE = IDX_W'(1);

  localparam logic [31:0] MSG_DISCOVERY_RESP = 32'd2;
  localparam logic [15:0] ELEM_CTRL_IPV4     = 16'd10;
  localparam logic [2:0]  ADDR_BYTES         = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_rewritten;
  } out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       sub;
    logic [1:0] sel;
  } cmd_t;

  function automatic logic [7:0] addr_byte(input logic [31:0] addr, input logic [1:0] sel);
    logic [31:0] sh;
    sh = addr >> {sel, 3'b000};
    return sh[7:0];
  endfunction

endpackage

>>> hw/rtl/cciprw_front.sv
// ----------------------------------------------------------------------------
// Rewriter front end
// Parses the packet byte by byte and tags address bytes for substitution.
// ----------------------------------------------------------------------------
module cciprw_front
  import cciprw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] listen_ipv4,
  input  logic        rewrite_enable,
  input  logic        take,
  input  in_t         item,
  output cmd_t        cmd
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_EHEAD,
    PH_EBODY,
    PH_PASS
  } phase_t;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [6:0]       header_bytes, header_bytes_next;
  logic [31:0]      type_shift, type_shift_next;
  logic [15:0]      message_left, message_left_next;
  logic [31:0]      element_head, element_head_next;
  logic [15:0]      element_left, element_left_next;
  logic [2:0]       sub_count, sub_count_next;

  logic        pos_ok;
  logic        sub_now;
  logic [2:0]  sub_idx;
  logic [7:0]  ob;
  logic [7:0]  b;
  logic [31:0] pos32;
  logic [31:0] hb32;
  logic [31:0] head_new;
  logic [16:0] total;
  logic [15:0] el_dec;

  assign b       = item.in_byte;
  assign pos_ok  = pos < POS_W'(MAX_PACKET);
  assign sub_now = pos_ok && (sub_count != 3'd0);
  assign sub_idx = sub_count - 3'd1;
  assign ob      = sub_now ? addr_byte(listen_ipv4, sub_idx[1:0]) : b;
  assign pos32   = 32'(pos);
  assign hb32    = 32'(header_bytes);
  assign head_new = {element_head[23:0], ob};
  assign total    = {1'b0, head_new[15:0]} + 17'd4;
  assign el_dec   = (element_left != 16'd0) ? element_left - 16'd1 : element_left;

  assign cmd.data = b;
  assign cmd.last = item.in_last;
  assign cmd.sub  = sub_now;
  assign cmd.sel  = sub_idx[1:0];

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    header_bytes_next = header_bytes;
    type_shift_next   = type_shift;
    message_left_next = message_left;
    element_head_next = element_head;
    element_left_next = element_left;
    sub_count_next    = sub_count;
    if (pos_ok) begin
      if (sub_now) begin
        sub_count_next = sub_idx;
      end
      unique case (phase)
        PH_IDLE: begin
          type_shift_next = {24'd0, b};
          phase_next      = (b == 8'd0) ? PH_HDR : PH_PASS;
        end
        PH_HDR: begin
          type_shift_next = {type_shift[23:0], b};
          if (pos == POS_W'(1)) begin
            header_bytes_next = {b[7:3], 2'b00};
          end
          priority if (pos32 == hb32 + 32'd3) begin
            if ({type_shift[23:0], b} != MSG_DISCOVERY_RESP) begin
              phase_next = PH_PASS;
            end
          end else if (pos32 == hb32 + 32'd5) begin
            message_left_next = {b, 8'd0};
          end else if (pos32 == hb32 + 32'd6) begin
            message_left_next = {message_left[15:8], b};
          end else if (pos32 == hb32 + 32'd7) begin
            if (message_left == 16'd0) begin
              phase_next = PH_PASS;
            end else begin
              phase_next        = PH_EHEAD;
              element_head_next = 32'd0;
              element_left_next = 16'd0;
            end
          end else begin
          end
        end
        PH_EHEAD: begin
          element_head_next = head_new;
          element_left_next = element_left + 16'd1;
          if (element_left >= 16'd3) begin
            if (head_new[31:16] == ELEM_CTRL_IPV4 && rewrite_enable) begin
              sub_count_next = ADDR_BYTES;
            end
            element_head_next = 32'd0;
            if (total >= {1'b0, message_left}) begin
              message_left_next = 16'd0;
              element_left_next = 16'd0;
              phase_next        = PH_PASS;
            end else begin
              message_left_next = message_left - total[15:0];
              if (head_new[15:0] == 16'd0) begin
                element_left_next = 16'd0;
              end else begin
                element_left_next = head_new[15:0];
                phase_next        = PH_EBODY;
              end
            end
          end
        end
        PH_EBODY: begin
          element_left_next = el_dec;
          if (el_dec == 16'd0) begin
            element_head_next = 32'd0;
            phase_next        = PH_EHEAD;
          end
        end
        PH_PASS: begin
        end
        default: begin
        end
      endcase
      pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pos          <= '0;
      header_bytes <= '0;
      type_shift   <= '0;
      message_left <= '0;
      element_head <= '0;
      element_left <= '0;
      sub_count    <= '0;
    end else if (take) begin
      if (item.in_last) begin
        phase        <= PH_IDLE;
        pos          <= '0;
        header_bytes <= '0;
        type_shift   <= '0;
        message_left <= '0;
        element_head <= '0;
        element_left <= '0;
        sub_count    <= '0;
      end else begin
        phase        <= phase_next;
        pos          <= pos_next;
        header_bytes <= header_bytes_next;
        type_shift   <= type_shift_next;
        message_left <= message_left_next;
        element_head <= element_head_next;
        element_left <= element_left_next;
        sub_count    <= sub_count_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_sub_count_bound: assert property (@(posedge clk) disable iff (rst)
    sub_count <= ADDR_BYTES)
    else $error("substitution count out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && item.in_last |=> phase == PH_IDLE && pos == '0 && sub_count == 3'd0)
    else $error("parse state not cleared after last word");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_PACKET))
    else $error("byte position beyond saturation");
`endif

endmodule

>>> hw/rtl/cciprw_queue.sv
// ----------------------------------------------------------------------------
// Rewriter command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module cciprw_queue
  import cciprw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic q_full,
  output logic q_empty
);

  cmd_t            slots [QDEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = count == QC_W'(QDEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + QC_W'(1);
        2'b01:   count <= count - QC_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == QC_W'(QDEPTH) || count == '0) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/cciprw_back.sv
// ----------------------------------------------------------------------------
// Rewriter back end
// Applies address substitution and holds the word on the result side.
// ----------------------------------------------------------------------------
module cciprw_back
  import cciprw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] listen_ipv4,
  input  cmd_t        cmd,
  input  logic        cmd_avail,
  output logic        cmd_take,
  input  logic        pop,
  output logic        empty,
  output out_t        result
);

  logic out_valid;
  out_t hold;

  assign cmd_take = cmd_avail && (!out_valid || pop);
  assign empty    = !out_valid;
  assign result   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      hold.out_byte      <= cmd.sub ? addr_byte(listen_ipv4, cmd.sel) : cmd.data;
      hold.out_last      <= cmd.last;
      hold.out_rewritten <= cmd.sub;
    end
  end

endmodule

>>> hw/rtl/capwap_control_ip_rewriter_unit.sv
// ----------------------------------------------------------------------------
// CAPWAP control address rewriter
// Streams packet words and writes the listen address into control address
// elements of discovery responses.
// ----------------------------------------------------------------------------
// Path: an accepted word is written into the queue, then registered in the result stage that drives the result ports.
// Throughput: one word per cycle while the queue is not full; the front parses each word as it is taken.
// The four-entry queue lets front and back stall independently.
// Reset: synchronous rst clears parse state, queue, result stage and registers.
module capwap_control_ip_rewriter_unit
  import cciprw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_t              item,
  output logic             empty,
  input  logic             pop,
  output out_t             result,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0] wr_data
);

  logic [31:0] listen_ipv4;
  logic        rewrite_enable;
  logic        take;
  cmd_t        front_cmd;
  cmd_t        back_cmd;
  logic        q_empty;
  logic        cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_ipv4    <= '0;
      rewrite_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LISTEN_IPV4:    listen_ipv4    <= wr_data[31:0];
        REG_REWRITE_ENABLE: rewrite_enable <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  assign take = push && !full;

  cciprw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .listen_ipv4    (listen_ipv4),
    .rewrite_enable (rewrite_enable),
    .take           (take),
    .item           (item),
    .cmd            (front_cmd)
  );

  cciprw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_cmd  (front_cmd),
    .rd      (cmd_take),
    .rd_cmd  (back_cmd),
    .q_full  (full),
    .q_empty (q_empty)
  );

  cciprw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .listen_ipv4 (listen_ipv4),
    .cmd         (back_cmd),
    .cmd_avail   (!q_empty),
    .cmd_take    (cmd_take),
    .pop         (pop),
    .empty       (empty),
    .result      (result)
  );

endmodule
